>>> design/dffd_pkg.sv
// Types and constants shared by the duplicate filter / forward decision block.
// No dependencies.
`default_nettype none
package dffd_pkg;

  // action codes
  localparam logic [2:0] ACT_DUP       = 3'd0;
  localparam logic [2:0] ACT_DELIVER   = 3'd1;
  localparam logic [2:0] ACT_FORWARD   = 3'd2;
  localparam logic [2:0] ACT_CONGESTED = 3'd3;
  localparam logic [2:0] ACT_TTL       = 3'd4;
  localparam logic [2:0] ACT_IGNORE    = 3'd5;

  // ack flag bits
  localparam logic [7:0] ACK_CONGESTED = 8'h80;
  localparam logic [7:0] ACK_DROPPED   = 8'h40;
  localparam logic [7:0] ACK_LIFETIME  = 8'h20;

  // packet header beat
  typedef struct packed {
    logic [3:0]  conn_id;
    logic [15:0] originator;
    logic [7:0]  end_seqno;
    logic [7:0]  hop_count;
    logic [3:0]  time_to_live;
    logic        have_route;
    logic        queue_room;
  } in_t;

  // decision beat
  typedef struct packed {
    logic [2:0] action;
    logic       ack_send;
    logic [7:0] ack_flags;
    logic [7:0] out_hops;
    logic [3:0] out_ttl;
  } out_t;

  // identity of a packet as kept in the seen table
  typedef struct packed {
    logic [3:0]  conn_id;
    logic [15:0] originator;
    logic [7:0]  end_seqno;
  } key_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the header
    logic eval;      // look up, record, decide
  } cmd_t;

endpackage
`default_nettype wire

>>> design/dffd_ctrl.sv
// Controller for the duplicate filter: accepts a header, then runs its
// evaluation state. Depends on dffd_pkg.
`default_nettype none
module dffd_ctrl
  import dffd_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  output cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state;
  logic state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EVAL;
      ST_EVAL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // outputs
  assign busy        = (state == ST_EVAL);
  assign cmd.capture = (state == ST_IDLE) && start;
  assign cmd.eval    = (state == ST_EVAL);

endmodule
`default_nettype wire

>>> design/dffd_dp.sv
// Datapath: header register, seen table with valid bits, round-robin
// insert pointer, sink register and decision logic. Depends on dffd_pkg.
`default_nettype none
module dffd_dp
  import dffd_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire       clk,
  input  wire       rst,
  input  wire cmd_t cmd,
  input  wire in_t  in_item,
  input  wire       cfg_we,
  input  wire       cfg_wdata,
  output logic      done,
  output out_t      result
);

  localparam int PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABLE_DEPTH - 1);

  in_t              hdr;
  key_t             entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  logic [PTR_W-1:0] insert_ptr;
  logic             is_sink;
  key_t             key;
  logic             hit;
  out_t             decision;

  // sink register
  always_ff @(posedge clk) begin
    if (rst)         is_sink <= 1'b0;
    else if (cfg_we) is_sink <= cfg_wdata;
  end

  // header capture
  always_ff @(posedge clk) begin
    if (cmd.capture) hdr <= in_item;
  end

  assign key = '{conn_id: hdr.conn_id, originator: hdr.originator,
                 end_seqno: hdr.end_seqno};

  // parallel compare against every entry
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (valid[k] && (entries[k] == key)) hit = 1'b1;
    end
  end

  // table update on a new packet
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      insert_ptr <= '0;
    end else if (cmd.eval && !hit) begin
      valid[insert_ptr] <= 1'b1;
      insert_ptr        <= (insert_ptr == PTR_LAST) ? '0 : insert_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && !hit) entries[insert_ptr] <= key;
  end

  // forwarding decision
  always_comb begin
    decision = '0;
    if (hit) begin
      decision.action   = ACT_DUP;
      decision.ack_send = 1'b1;
    end else if (is_sink) begin
      decision.action   = ACT_DELIVER;
      decision.ack_send = 1'b1;
    end else if (hdr.time_to_live <= 4'd1) begin
      decision.action    = ACT_TTL;
      decision.ack_send  = 1'b1;
      decision.ack_flags = ACK_DROPPED | ACK_LIFETIME;
    end else if (!hdr.have_route) begin
      decision.action = ACT_IGNORE;
    end else if (!hdr.queue_room) begin
      decision.action    = ACT_CONGESTED;
      decision.ack_send  = 1'b1;
      decision.ack_flags = ACK_DROPPED | ACK_CONGESTED;
    end else begin
      decision.action   = ACT_FORWARD;
      decision.ack_send = 1'b1;
      decision.out_hops = (hdr.hop_count == 8'hFF) ? 8'hFF : hdr.hop_count + 8'd1;
      decision.out_ttl  = hdr.time_to_live - 4'd1;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.eval;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) result <= decision;
  end

endmodule
`default_nettype wire

>>> design/duplicate_filter_forward_decision_top.sv
// Top level of the duplicate filter / forward decision block.
// Depends on dffd_pkg, dffd_ctrl and dffd_dp.
`default_nettype none
// A header is taken when start is high and busy is low, and latched. While
// busy is high the seen table is compared in parallel, updated and the
// decision registered. The result shows on result for exactly one cycle,
// marked by done, in the cycle in which busy falls; a new header may be
// started in that same cycle. The receiver cannot stall, so done must be
// sampled when it occurs. Users must write is_sink via cfg_we/cfg_wdata
// only while no header is in flight; the block does not enforce this.
module duplicate_filter_forward_decision_top
  import dffd_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire      clk,
  input  wire      rst,
  input  wire      start,
  output logic     busy,
  input  wire in_t in_item,
  output logic     done,
  output out_t     result,
  input  wire      cfg_we,
  input  wire      cfg_wdata
);

  cmd_t cmd;

  // controller
  dffd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath
  dffd_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  // an accepted beat is evaluated next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted header did not enter evaluation");

  // every evaluation yields exactly one strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("evaluation did not produce a result");

  // no strobe without a preceding evaluation
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without evaluation");

  // duplicates never carry flags or forward fields
  a_dup_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.action == ACT_DUP) |->
      (result.ack_flags == 8'h00 && result.out_hops == 8'h00 && result.ack_send))
    else $error("malformed duplicate result");

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the duplicate filter / forward decision block.
// Depends on dffd_pkg and duplicate_filter_forward_decision_top; it predicts
// every decision in step with the block and checks each done beat against it.
`default_nettype none
module testbench
  import dffd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam int RECENT_DEPTH = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic busy;
  logic done;
  out_t result;

  duplicate_filter_forward_decision_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state: seen table, insert slot, sink register
  key_t        seen_keys [TABLE_DEPTH];
  logic        seen_valid[TABLE_DEPTH];
  int          next_slot = 0;
  logic        sink_mode = 1'b0;

  out_t        pending_decisions[$];
  key_t        recent_keys[$];
  int unsigned mismatches = 0;
  int unsigned packets_sent = 0;
  int unsigned sink_writes = 0;
  int unsigned action_count[8];
  int unsigned cycles = 0;
  bit          no_gaps = 1'b0;

  initial begin
    foreach (seen_valid[i]) seen_valid[i] = 1'b0;
    foreach (action_count[i]) action_count[i] = 0;
  end

  // expected decision for one accepted header; updates the predicted table
  function automatic out_t decide_packet(in_t pkt);
    out_t r;
    key_t k;
    r = '0;
    k = {pkt.conn_id, pkt.originator, pkt.end_seqno};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (seen_valid[i] && seen_keys[i] == k) begin
        r.action = ACT_DUP;
        r.ack_send = 1'b1;
        return r;
      end
    end
    seen_keys[next_slot] = k;
    seen_valid[next_slot] = 1'b1;
    next_slot = (next_slot + 1) % TABLE_DEPTH;
    r.ack_send = 1'b1;
    if (sink_mode) begin
      r.action = ACT_DELIVER;
    end else if (pkt.time_to_live > 4'd1 && pkt.have_route) begin
      if (pkt.queue_room) begin
        r.action = ACT_FORWARD;
        r.out_hops = (pkt.hop_count == 8'hFF) ? 8'hFF : pkt.hop_count + 8'd1;
        r.out_ttl = pkt.time_to_live - 4'd1;
      end else begin
        r.action = ACT_CONGESTED;
        r.ack_flags = ACK_DROPPED | ACK_CONGESTED;
      end
    end else if (pkt.time_to_live <= 4'd1) begin
      r.action = ACT_TTL;
      r.ack_flags = ACK_DROPPED | ACK_LIFETIME;
    end else begin
      r.action = ACT_IGNORE;
      r.ack_send = 1'b0;
    end
    return r;
  endfunction

  function automatic in_t make_pkt(logic [3:0] conn, logic [15:0] orig, logic [7:0] seq,
                                   logic [7:0] hops, logic [3:0] ttl, logic route,
                                   logic room);
    in_t p;
    p.conn_id = conn;
    p.originator = orig;
    p.end_seqno = seq;
    p.hop_count = hops;
    p.time_to_live = ttl;
    p.have_route = route;
    p.queue_room = room;
    return p;
  endfunction

  task automatic note_mismatch(string what, out_t exp_d, out_t act_d);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s: exp act=%0d ack=%0b flags=%h hops=%0d ttl=%0d | got act=%0d ack=%0b flags=%h hops=%0d ttl=%0d",
               $realtime, what, exp_d.action, exp_d.ack_send, exp_d.ack_flags,
               exp_d.out_hops, exp_d.out_ttl, act_d.action, act_d.ack_send,
               act_d.ack_flags, act_d.out_hops, act_d.out_ttl);
  endtask

  // send one header beat; start stays high after acceptance when the next
  // beat follows with no gap
  task automatic send_packet(in_t pkt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= pkt;
    do @(posedge clk); while (busy);
    pending_decisions.push_back(decide_packet(pkt));
    packets_sent++;
  endtask

  // lower start, wait for every decision, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sink(logic value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sink_mode = value;
    sink_writes++;
  endtask

  // decision check on every done beat
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_decisions.size() == 0) begin
        note_mismatch("unexpected decision", '0, result);
      end else begin
        out_t exp_d;
        exp_d = pending_decisions.pop_front();
        if (result.action !== exp_d.action || result.ack_send !== exp_d.ack_send ||
            result.ack_flags !== exp_d.ack_flags || result.out_hops !== exp_d.out_hops ||
            result.out_ttl !== exp_d.out_ttl)
          note_mismatch("decision mismatch", exp_d, result);
        else
          action_count[result.action]++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding",
               cycles, pending_decisions.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // every non-duplicate outcome at a non-sink node, field extremes and hop saturation
  task automatic test_decisions();
    send_packet(make_pkt(4'h0, 16'h0000, 8'h00, 8'h00, 4'd2, 1'b1, 1'b1));
    send_packet(make_pkt(4'hF, 16'hFFFF, 8'hFF, 8'hFF, 4'd15, 1'b1, 1'b1));
    send_packet(make_pkt(4'h1, 16'h1234, 8'h01, 8'hFE, 4'd3, 1'b1, 1'b1));
    send_packet(make_pkt(4'h2, 16'h5678, 8'h02, 8'h10, 4'd15, 1'b1, 1'b0));
    send_packet(make_pkt(4'h3, 16'h9ABC, 8'h03, 8'h20, 4'd0, 1'b1, 1'b1));
    send_packet(make_pkt(4'h4, 16'hDEF0, 8'h04, 8'h30, 4'd1, 1'b0, 1'b0));
    send_packet(make_pkt(4'h5, 16'hAAAA, 8'h05, 8'h40, 4'd2, 1'b0, 1'b1));
    send_packet(make_pkt(4'h6, 16'h5555, 8'h06, 8'h50, 4'd15, 1'b0, 1'b0));
    drain();
  endtask

  // duplicate hit ignores hop/ttl/flags; any key field difference is new
  task automatic test_duplicates();
    send_packet(make_pkt(4'h5, 16'hBEEF, 8'h07, 8'h03, 4'd5, 1'b1, 1'b1));
    send_packet(make_pkt(4'h5, 16'hBEEF, 8'h07, 8'h09, 4'd0, 1'b0, 1'b0));
    send_packet(make_pkt(4'h6, 16'hBEEF, 8'h07, 8'h03, 4'd5, 1'b1, 1'b1));
    send_packet(make_pkt(4'h5, 16'hBEEE, 8'h07, 8'h03, 4'd5, 1'b1, 1'b1));
    send_packet(make_pkt(4'h5, 16'hBEEF, 8'h08, 8'h03, 4'd5, 1'b1, 1'b1));
    send_packet(make_pkt(4'h5, 16'hBEEF, 8'h07, 8'hFF, 4'd15, 1'b1, 1'b0));
    drain();
  endtask

  // sink delivers new packets whatever ttl/route/room say
  task automatic test_sink();
    write_sink(1'b1);
    send_packet(make_pkt(4'h9, 16'h0F0F, 8'h80, 8'h00, 4'd0, 1'b0, 1'b0));
    send_packet(make_pkt(4'h9, 16'h0F0F, 8'h80, 8'h00, 4'd0, 1'b0, 1'b0));
    send_packet(make_pkt(4'hA, 16'hF0F0, 8'h7F, 8'hFF, 4'd15, 1'b1, 1'b1));
    send_packet(make_pkt(4'h5, 16'hBEEF, 8'h07, 8'h01, 4'd2, 1'b1, 1'b1));
    write_sink(1'b0);
  endtask

  // random headers; a share reuses recent keys so hits, misses and evicted
  // entries all occur; gapless bursts alternate with gapped stretches
  task automatic test_random(logic sink, int count);
    key_t k;
    in_t  p;
    write_sink(sink);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (recent_keys.size() != 0 && $urandom_range(0, 99) < 40)
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
        k = key_t'($urandom);
      p = make_pkt(k.conn_id, k.originator, k.end_seqno, 8'($urandom),
                   4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
      case ($urandom_range(0, 7))
        0: p.hop_count = 8'hFF;
        1: p.hop_count = 8'hFE;
        default: ;
      endcase
      send_packet(p);
      recent_keys.push_back(k);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_decisions();
    test_duplicates();
    test_sink();
    test_random(1'b0, 400);
    test_random(1'b1, 200);
    test_random(1'b0, 300);
    test_random(1'b1, 100);
    test_random(1'b0, 100);
    drain();

    if (pending_decisions.size() != 0) begin
      mismatches += pending_decisions.size();
      $display("%0d decisions never arrived", pending_decisions.size());
    end
    $display("%0d headers over %0d is_sink writes: dup %0d deliver %0d forward %0d",
             packets_sent, sink_writes, action_count[ACT_DUP], action_count[ACT_DELIVER],
             action_count[ACT_FORWARD]);
    $display("congested %0d ttl drop %0d ignored %0d, %0d mismatches",
             action_count[ACT_CONGESTED], action_count[ACT_TTL],
             action_count[ACT_IGNORE], mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
